// ===== sv/fpsc_pkg.sv =====
package fpsc_pkg;

  localparam int QUARTER_ENTRIES = 128;
  localparam int FRACTION_BITS   = 16;
  localparam int POS_BITS        = 9;
  localparam int PHASE_BITS      = POS_BITS + FRACTION_BITS;
  localparam int ROM_ENTRIES     = QUARTER_ENTRIES + 1;
  localparam int ADDR_BITS       = $clog2(ROM_ENTRIES);
  localparam int AMP_BITS        = 16;
  localparam int VALUE_BITS      = AMP_BITS + 1;
  localparam int IN_TDATA_BITS   = ((PHASE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;

  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  typedef logic [AMP_BITS-1:0] amp_t;

  // Interpolation operands carried from the table stage to the multiply stage.
  typedef struct packed {
    logic                     neg;
    amp_t                     lo;
    amp_t                     diff;
    logic [FRACTION_BITS-1:0] frac;
  } fpsc_interp_t;

  // First quadrant of sin, 1.0 == 65536, last entry saturated to 65535.
  localparam amp_t QROM [0:ROM_ENTRIES-1] = '{
    16'd0,     16'd804,   16'd1608,  16'd2412,  16'd3216,  16'd4019,  16'd4821,
    16'd5623,  16'd6424,  16'd7224,  16'd8022,  16'd8820,  16'd9616,  16'd10411,
    16'd11204, 16'd11996, 16'd12785, 16'd13573, 16'd14359, 16'd15143, 16'd15924,
    16'd16703, 16'd17479, 16'd18253, 16'd19024, 16'd19792, 16'd20557, 16'd21320,
    16'd22078, 16'd22834, 16'd23586, 16'd24335, 16'd25080, 16'd25821, 16'd26558,
    16'd27291, 16'd28020, 16'd28745, 16'd29466, 16'd30182, 16'd30893, 16'd31600,
    16'd32303, 16'd33000, 16'd33692, 16'd34380, 16'd35062, 16'd35738, 16'd36410,
    16'd37076, 16'd37736, 16'd38391, 16'd39040, 16'd39683, 16'd40320, 16'd40951,
    16'd41576, 16'd42194, 16'd42806, 16'd43412, 16'd44011, 16'd44604, 16'd45190,
    16'd45769, 16'd46341, 16'd46906, 16'd47464, 16'd48015, 16'd48559, 16'd49095,
    16'd49624, 16'd50146, 16'd50660, 16'd51166, 16'd51665, 16'd52156, 16'd52639,
    16'd53114, 16'd53581, 16'd54040, 16'd54491, 16'd54934, 16'd55368, 16'd55794,
    16'd56212, 16'd56621, 16'd57022, 16'd57414, 16'd57798, 16'd58172, 16'd58538,
    16'd58896, 16'd59244, 16'd59583, 16'd59914, 16'd60235, 16'd60547, 16'd60851,
    16'd61145, 16'd61429, 16'd61705, 16'd61971, 16'd62228, 16'd62476, 16'd62714,
    16'd62943, 16'd63162, 16'd63372, 16'd63572, 16'd63763, 16'd63944, 16'd64115,
    16'd64277, 16'd64429, 16'd64571, 16'd64704, 16'd64827, 16'd64940, 16'd65043,
    16'd65137, 16'd65220, 16'd65294, 16'd65358, 16'd65413, 16'd65457, 16'd65492,
    16'd65516, 16'd65531, 16'd65535
  };

  // Positions past the stored quarter read as zero.
  function automatic amp_t rom_read(input logic [ADDR_BITS-1:0] addr);
    amp_t res;
    res = '0;
    if (int'(addr) < ROM_ENTRIES) begin
      res = QROM[addr];
    end
    return res;
  endfunction

endpackage

// ===== sv/fixed_phase_sine_cosine_lookup.sv =====
// Sine/cosine of a 25-bit phase (full turn = 2^25: 9-bit table position over a
// 16-bit fraction), selected per word by in_tuser (0 sine, 1 cosine). The phase
// is folded into the first quadrant, two neighboring entries of a 129-entry
// quarter-wave table are read, and the result interpolates linearly between
// them, returned as a 17-bit two's complement value in units of 1/65536
// (range -65535..65535). Throughput is one word per clock unless the consumer
// stalls; out_tvalid rises once a word has passed the input register (loaded at
// acceptance), the table-read register and the multiply/output register. The
// 16x16 interpolation multiply sets the critical stage. The pipeline advances
// whenever the output register is empty or being drained, so a stalled
// consumer holds every stage in place.
module fixed_phase_sine_cosine_lookup
  import fpsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [24:0] phase, rest zero
  input  logic [0:0]                in_tuser,   // [0] operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata   // [16:0] value, rest zero
);

  localparam logic [ADDR_BITS-1:0] QTR     = ADDR_BITS'(QUARTER_ENTRIES);
  localparam logic [ADDR_BITS-1:0] QTR_M1  = ADDR_BITS'(QUARTER_ENTRIES - 1);
  localparam logic [ADDR_BITS:0]   HALF    = (ADDR_BITS + 1)'(2 * QUARTER_ENTRIES);

  logic ce;

  // Stage 1: input register.
  logic                  v1_r;
  logic                  op1_r;
  logic [PHASE_BITS-1:0] ph1_r;

  // Stage 2: folded table read.
  logic         v2_r;
  fpsc_interp_t s2_r;
  fpsc_interp_t s2_nxt;

  // Stage 3: output register.
  logic                  v3_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;

  // Advance all stages together unless the output word is held.
  assign ce        = !v3_r || out_tready;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      op1_r   <= in_tuser[0];
      ph1_r   <= in_tdata[PHASE_BITS-1:0];
      s2_r    <= s2_nxt;
      value_r <= value_nxt;
    end
  end

  // Fold into the first quadrant and pick the table address and weight.
  always_comb begin
    logic [POS_BITS-1:0]      pos;
    logic [ADDR_BITS-1:0]     p;
    logic [FRACTION_BITS-1:0] f;
    logic [ADDR_BITS-1:0]     addr;
    logic                     neg;
    amp_t                     lo;
    amp_t                     hi;

    pos = ph1_r[PHASE_BITS-1:FRACTION_BITS];
    f   = ph1_r[FRACTION_BITS-1:0];
    neg = pos[POS_BITS-1];
    p   = pos[ADDR_BITS-1:0];

    // Second quadrant of the half turn: mirror about the quarter point.
    if (p[ADDR_BITS-1]) begin
      if (op1_r == OP_COSINE) begin
        neg = !neg;
      end
      if (f != '0) begin
        p = ~p;
        f = FRACTION_BITS'(0) - f;
      end else begin
        p = ADDR_BITS'(HALF - {1'b0, p});
      end
    end

    // Cosine reads the sine table from the far end of the quarter.
    addr = p;
    if (op1_r == OP_COSINE) begin
      if (f != '0) begin
        addr = QTR_M1 - p;
        f    = FRACTION_BITS'(0) - f;
      end else begin
        addr = QTR - p;
      end
    end

    lo = rom_read(addr);
    hi = rom_read(addr + ADDR_BITS'(1));

    s2_nxt.neg  = neg;
    s2_nxt.lo   = lo;
    s2_nxt.diff = (hi >= lo) ? (hi - lo) : '0;
    s2_nxt.frac = f;
  end

  // Interpolate and apply the sign; a zero weight leaves the base entry.
  always_comb begin
    logic [AMP_BITS+FRACTION_BITS-1:0] prod;
    logic [VALUE_BITS-1:0]             mag;

    prod = s2_r.diff * s2_r.frac;
    mag  = VALUE_BITS'(s2_r.lo) + VALUE_BITS'(prod[AMP_BITS+FRACTION_BITS-1:FRACTION_BITS]);
    value_nxt = s2_r.neg ? (VALUE_BITS'(0) - mag) : mag;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {{(OUT_TDATA_BITS-VALUE_BITS){1'b0}}, value_r};

  // Interpolated magnitude never passes the top table entry.
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ({1'b0, s2_r.lo} + {1'b0, s2_r.diff}) <= VALUE_BITS'(65535))
    else $error("interpolated magnitude out of range");

  // The most negative code is never produced.
  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VALUE_BITS-1:0] != {1'b1, {(VALUE_BITS-1){1'b0}}})
    else $error("output hit the most negative code");

  // An accepted word reaches the input register on the next edge.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted word lost at input register");

  // A word in the table stage reaches the output when the pipe advances.
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && ce) |=> out_tvalid)
    else $error("word lost between table and output stage");

endmodule
